FILE: sv/sepig_pkg.sv
// Shared widths, codes and types for the Sampson epipolar inlier gate.
package sepig_pkg;

  // Default input widths
  localparam int COORD_WIDTH_DEF = 16;
  localparam int COEF_WIDTH_DEF  = 16;

  // Core formats: coordinates Q3.12, coefficients Q1.14
  localparam int CORE_W    = 16;
  localparam int ONE_SHIFT = 12;   // 1.0 in Q3.12 is 1 << 12

  localparam int IDX_W    = 4;
  localparam int NUM_COEF = 9;

  // Datapath widths
  localparam int PROD_W = 2 * CORE_W;            // coefficient times coordinate
  localparam int LINE_W = 2 * CORE_W + 1;        // u, v, w, s, t (signed)
  localparam int MAG_W  = LINE_W - 1;            // |u| and friends
  localparam int SQ_W   = 2 * MAG_W;             // squared line term
  localparam int DEN_W  = SQ_W + 2;              // sum of four squares
  localparam int PR_W   = CORE_W + LINE_W;       // coordinate times line term
  localparam int RES_W  = PR_W + 2;              // residual r (signed)
  localparam int RMAG_W = RES_W - 1;             // |r|
  localparam int LO_W   = 32;
  localparam int HI_W   = RMAG_W - LO_W;
  localparam int NUM_SHIFT = 6;
  localparam int NUM_W  = 2 * RMAG_W + NUM_SHIFT; // r^2 << 6
  localparam int Q_W    = 32;                     // quotient, Q2.30

  // Output queue
  localparam int FIFO_DEPTH = 64;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

  // Stream codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  // Register map (word index)
  localparam logic REG_INLIER_THRESHOLD = 1'b0;
  localparam logic [31:0] THRESHOLD_RESET = 32'd10737;

  localparam int OUT_FIELDS_W = 1 + Q_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Flags carried alongside the divider data
  typedef struct packed {
    logic valid;
    logic degen;
    logic sat;
  } div_ctl_t;

  // One result, lowest field in the lowest bit
  typedef struct packed {
    logic           degenerate;
    logic [Q_W-1:0] sampson_distance;
    logic           is_inlier;
  } result_t;

endpackage

FILE: sv/sepig_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
module sepig_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  sepig_pkg::div_ctl_t            in_ctl,
  input  logic [sepig_pkg::NUM_W-1:0]    in_num,
  input  logic [sepig_pkg::DEN_W-1:0]    in_den,
  output sepig_pkg::div_ctl_t            out_ctl,
  output logic [sepig_pkg::Q_W-1:0]      out_quot
);

  localparam int NW = sepig_pkg::NUM_W;
  localparam int DW = sepig_pkg::DEN_W;
  localparam int QW = sepig_pkg::Q_W;

  sepig_pkg::div_ctl_t ctl [0:QW];
  logic [NW-1:0]       rem [0:QW];
  logic [DW-1:0]       dv  [0:QW];
  logic [QW-1:0]       quo [0:QW];

  assign ctl[0] = in_ctl;
  assign rem[0] = in_num;
  assign dv[0]  = in_den;
  assign quo[0] = '0;

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int SH = QW - 1 - j;
    logic [NW-1:0] part;
    logic          ge;

    assign part = NW'(dv[j]) << SH;
    assign ge   = (rem[j] >= part);

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[j+1] <= '0;
      end else begin
        ctl[j+1] <= ctl[j];
      end
    end

    // Bit SH is still clear here; earlier stages only set higher bits
    always_ff @(posedge clk) begin
      rem[j+1] <= ge ? (rem[j] - part) : rem[j];
      dv[j+1]  <= dv[j];
      quo[j+1] <= quo[j] | (QW'(ge) << SH);
    end
  end

  assign out_ctl  = ctl[QW];
  assign out_quot = quo[QW];

endmodule

FILE: sv/sampson_epipolar_inlier_gate.sv
// Sampson epipolar inlier gate: top level with arithmetic pipeline and output queue.
// A test transfer passes stages 0 to 8, the divider stages, the queue and the output register.
// Throughput: one item per cycle; s_axis_tready drops only with 64 test results outstanding.
// Load transfers produce no result and update the coefficient store at their accept edge.
// Reset (rst, synchronous, active high): threshold to 10737, all nine coefficients to zero,
//   pipeline valids, queue and output register emptied.
module sampson_epipolar_inlier_gate #(
  parameter int COORD_WIDTH = sepig_pkg::COORD_WIDTH_DEF,
  parameter int COEF_WIDTH  = sepig_pkg::COEF_WIDTH_DEF,
  localparam int IN_FIELDS_W = sepig_pkg::IDX_W + COEF_WIDTH + 4 * COORD_WIDTH,
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst,
  // Slave stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // coef_index, coef_value, train_x, train_y, query_x, query_y (lowest first), zero pad
  input  logic [IN_TDATA_W-1:0]               s_axis_tdata,
  // command: 0 load coefficient, 1 test pair
  input  logic                                s_axis_tuser,
  // Master stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // is_inlier, sampson_distance, degenerate (lowest first), zero pad
  output logic [sepig_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // Configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int CW  = sepig_pkg::CORE_W;
  localparam int IW  = sepig_pkg::IDX_W;
  localparam int LW  = sepig_pkg::LINE_W;
  localparam int PW  = sepig_pkg::PROD_W;
  localparam int RW  = sepig_pkg::RES_W;
  localparam int OS  = sepig_pkg::ONE_SHIFT;

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [31:0] inlier_threshold;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == sepig_pkg::REG_INLIER_THRESHOLD) ? inlier_threshold : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      inlier_threshold <= sepig_pkg::THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == sepig_pkg::REG_INLIER_THRESHOLD)) begin
      inlier_threshold <= pwdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Input unpacking and reduction to the core formats (floor shift or zero fill)
  // ---------------------------------------------------------------------------
  logic [IW-1:0]         in_idx;
  logic [COEF_WIDTH-1:0] in_coef;
  logic signed [CW-1:0]  coef_core;
  logic signed [CW-1:0]  pt_core [0:3];   // train_x, train_y, query_x, query_y

  assign in_idx  = s_axis_tdata[IW-1:0];
  assign in_coef = s_axis_tdata[IW +: COEF_WIDTH];

  if (COEF_WIDTH >= CW) begin : g_coef_narrow
    assign coef_core = in_coef[COEF_WIDTH-1 -: CW];
  end else begin : g_coef_widen
    assign coef_core = {in_coef, {(CW-COEF_WIDTH){1'b0}}};
  end

  for (genvar k = 0; k < 4; k++) begin : g_pt
    logic [COORD_WIDTH-1:0] raw;
    assign raw = s_axis_tdata[IW + COEF_WIDTH + k*COORD_WIDTH +: COORD_WIDTH];
    if (COORD_WIDTH >= CW) begin : g_narrow
      assign pt_core[k] = raw[COORD_WIDTH-1 -: CW];
    end else begin : g_widen
      assign pt_core[k] = {raw, {(CW-COORD_WIDTH){1'b0}}};
    end
  end

  logic s_xfer, s_test, s_load;
  assign s_xfer = s_axis_tvalid && s_axis_tready;
  assign s_test = s_xfer && (s_axis_tuser == sepig_pkg::CMD_TEST);
  assign s_load = s_xfer && (s_axis_tuser == sepig_pkg::CMD_LOAD);

  // Coefficient store, kept in core format, row-major
  logic signed [CW-1:0] coef_store [0:sepig_pkg::NUM_COEF-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sepig_pkg::NUM_COEF; i++) coef_store[i] <= '0;
    end else if (s_load && (in_idx < IW'(sepig_pkg::NUM_COEF))) begin
      coef_store[in_idx] <= coef_core;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: register the point pair
  // ---------------------------------------------------------------------------
  logic                 v0;
  logic signed [CW-1:0] tx0, ty0, qx0, qy0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else     v0 <= s_test;
  end

  always_ff @(posedge clk) begin
    tx0 <= pt_core[0];
    ty0 <= pt_core[1];
    qx0 <= pt_core[2];
    qy0 <= pt_core[3];
  end

  // ---------------------------------------------------------------------------
  // Stage 1: coefficient-coordinate products; the store is sampled here
  // ---------------------------------------------------------------------------
  logic                 v1;
  logic signed [PW-1:0] p_f0tx, p_f1ty, p_f3tx, p_f4ty, p_f6tx, p_f7ty;
  logic signed [PW-1:0] p_f0qx, p_f3qy, p_f1qx, p_f4qy;
  logic signed [CW-1:0] f2_1, f5_1, f6_1, f7_1, f8_1, qx1, qy1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= v0;
  end

  always_ff @(posedge clk) begin
    p_f0tx <= coef_store[0] * tx0;
    p_f1ty <= coef_store[1] * ty0;
    p_f3tx <= coef_store[3] * tx0;
    p_f4ty <= coef_store[4] * ty0;
    p_f6tx <= coef_store[6] * tx0;
    p_f7ty <= coef_store[7] * ty0;
    p_f0qx <= coef_store[0] * qx0;
    p_f3qy <= coef_store[3] * qy0;
    p_f1qx <= coef_store[1] * qx0;
    p_f4qy <= coef_store[4] * qy0;
    f2_1   <= coef_store[2];
    f5_1   <= coef_store[5];
    f6_1   <= coef_store[6];
    f7_1   <= coef_store[7];
    f8_1   <= coef_store[8];
    qx1    <= qx0;
    qy1    <= qy0;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: line terms u, v, w = F x1 and s, t from F' x2 (Q.26)
  // ---------------------------------------------------------------------------
  logic                 v2;
  logic signed [LW-1:0] u2, v2l, w2, s2, t2;
  logic signed [CW-1:0] qx2, qy2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
  end

  always_ff @(posedge clk) begin
    u2  <= LW'(p_f0tx) + LW'(p_f1ty) + (LW'(f2_1) <<< OS);
    v2l <= LW'(p_f3tx) + LW'(p_f4ty) + (LW'(f5_1) <<< OS);
    w2  <= LW'(p_f6tx) + LW'(p_f7ty) + (LW'(f8_1) <<< OS);
    s2  <= LW'(p_f0qx) + LW'(p_f3qy) + (LW'(f6_1) <<< OS);
    t2  <= LW'(p_f1qx) + LW'(p_f4qy) + (LW'(f7_1) <<< OS);
    qx2 <= qx1;
    qy2 <= qy1;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: residual products and line-term magnitudes
  // ---------------------------------------------------------------------------
  logic                                  v3;
  logic signed [sepig_pkg::PR_W-1:0]     pu3, pv3;
  logic signed [LW-1:0]                  w3;
  logic [sepig_pkg::MAG_W-1:0]           au3, av3, as3, at3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
  end

  always_ff @(posedge clk) begin
    pu3 <= qx2 * u2;
    pv3 <= qy2 * v2l;
    w3  <= w2;
    au3 <= sepig_pkg::MAG_W'(u2[LW-1]  ? -u2  : u2);
    av3 <= sepig_pkg::MAG_W'(v2l[LW-1] ? -v2l : v2l);
    as3 <= sepig_pkg::MAG_W'(s2[LW-1]  ? -s2  : s2);
    at3 <= sepig_pkg::MAG_W'(t2[LW-1]  ? -t2  : t2);
  end

  // ---------------------------------------------------------------------------
  // Stage 4: residual r = x2' F x1 (Q.38) and the four squares
  // ---------------------------------------------------------------------------
  logic                           v4;
  logic signed [RW-1:0]           r4;
  logic [sepig_pkg::SQ_W-1:0]     su4, sv4, ss4, st4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
  end

  always_ff @(posedge clk) begin
    r4  <= RW'(pu3) + RW'(pv3) + (RW'(w3) <<< OS);
    su4 <= au3 * au3;
    sv4 <= av3 * av3;
    ss4 <= as3 * as3;
    st4 <= at3 * at3;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: |r| and the denominator
  // ---------------------------------------------------------------------------
  logic                            v5;
  logic [sepig_pkg::RMAG_W-1:0]    rm5;
  logic [sepig_pkg::DEN_W-1:0]     den5;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= v4;
  end

  always_ff @(posedge clk) begin
    rm5  <= sepig_pkg::RMAG_W'(r4[RW-1] ? -r4 : r4);
    den5 <= sepig_pkg::DEN_W'(su4) + sepig_pkg::DEN_W'(sv4) +
            sepig_pkg::DEN_W'(ss4) + sepig_pkg::DEN_W'(st4);
  end

  // ---------------------------------------------------------------------------
  // Stage 6: r^2 as three partial products (hi*hi, hi*lo, lo*lo)
  // ---------------------------------------------------------------------------
  localparam int LO = sepig_pkg::LO_W;
  localparam int HI = sepig_pkg::HI_W;

  logic                          v6;
  logic [2*HI-1:0]               hh6;
  logic [HI+LO-1:0]              hl6;
  logic [2*LO-1:0]               ll6;
  logic [sepig_pkg::DEN_W-1:0]   den6;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else     v6 <= v5;
  end

  always_ff @(posedge clk) begin
    hh6  <= rm5[LO +: HI] * rm5[LO +: HI];
    hl6  <= rm5[LO +: HI] * rm5[LO-1:0];
    ll6  <= rm5[LO-1:0] * rm5[LO-1:0];
    den6 <= den5;
  end

  // ---------------------------------------------------------------------------
  // Stage 7: numerator r^2 << 6
  // ---------------------------------------------------------------------------
  localparam int NW = sepig_pkg::NUM_W;
  localparam int NS = sepig_pkg::NUM_SHIFT;

  logic                          v7;
  logic [NW-1:0]                 num7;
  logic [sepig_pkg::DEN_W-1:0]   den7;

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else     v7 <= v6;
  end

  always_ff @(posedge clk) begin
    num7 <= (NW'(hh6) << (2*LO + NS)) + (NW'(hl6) << (LO + 1 + NS)) + (NW'(ll6) << NS);
    den7 <= den6;
  end

  // ---------------------------------------------------------------------------
  // Stage 8: zero-denominator and overflow detection ahead of the divider
  // ---------------------------------------------------------------------------
  sepig_pkg::div_ctl_t           ctl8;
  logic [NW-1:0]                 num8;
  logic [sepig_pkg::DEN_W-1:0]   den8;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl8 <= '0;
    end else begin
      ctl8.valid <= v7;
      ctl8.degen <= (den7 == '0);
      ctl8.sat   <= (num7 >= (NW'(den7) << sepig_pkg::Q_W));
    end
  end

  always_ff @(posedge clk) begin
    num8 <= num7;
    den8 <= den7;
  end

  // ---------------------------------------------------------------------------
  // Stages 9..40: quotient bits, most significant first
  // ---------------------------------------------------------------------------
  sepig_pkg::div_ctl_t          dctl;
  logic [sepig_pkg::Q_W-1:0]    dquot;

  sepig_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .in_ctl   (ctl8),
    .in_num   (num8),
    .in_den   (den8),
    .out_ctl  (dctl),
    .out_quot (dquot)
  );

  // Final result: saturate on overflow or zero denominator, then threshold
  sepig_pkg::result_t res;

  always_comb begin
    res.degenerate       = dctl.degen;
    res.sampson_distance = (dctl.degen || dctl.sat) ? '1 : dquot;
    res.is_inlier        = !dctl.degen && (res.sampson_distance < inlier_threshold);
  end

  // ---------------------------------------------------------------------------
  // Output queue and output register. Credit: s_axis_tready only while fewer
  // than FIFO_DEPTH test items are outstanding, so the queue cannot overflow.
  // ---------------------------------------------------------------------------
  sepig_pkg::result_t                fifo_mem [0:sepig_pkg::FIFO_DEPTH-1];
  logic [sepig_pkg::PTR_W-1:0]       wr_ptr, rd_ptr;
  logic [sepig_pkg::OCC_W-1:0]       fifo_cnt, fifo_cnt_next;
  logic [sepig_pkg::OCC_W-1:0]       occ, occ_next;
  sepig_pkg::result_t                out_res;
  logic                              push, pop, m_xfer;

  assign push   = dctl.valid;
  assign pop    = (fifo_cnt != '0) && (!m_axis_tvalid || m_axis_tready);
  assign m_xfer = m_axis_tvalid && m_axis_tready;

  assign s_axis_tready = (occ < sepig_pkg::OCC_W'(sepig_pkg::FIFO_DEPTH));

  always_comb begin
    fifo_cnt_next = fifo_cnt;
    if (push) fifo_cnt_next = fifo_cnt_next + 1'b1;
    if (pop)  fifo_cnt_next = fifo_cnt_next - 1'b1;
    occ_next = occ;
    if (s_test) occ_next = occ_next + 1'b1;
    if (m_xfer) occ_next = occ_next - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      fifo_cnt      <= '0;
      occ           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      fifo_cnt <= fifo_cnt_next;
      occ      <= occ_next;
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (pop)
        m_axis_tvalid <= 1'b1;
      else if (m_axis_tready)
        m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_mem[wr_ptr] <= res;
    if (pop)  out_res <= fifo_mem[rd_ptr];
  end

  assign m_axis_tdata = sepig_pkg::OUT_TDATA_W'(out_res);

endmodule
